FILE: sv/tlmd_pkg.sv
// Shared types and constants of the thresholded 3x3 local maximum detector.
// No dependencies; all files but tlmd_ram refer to it by scoped names.
package tlmd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIXEL_BITS = 32;
	localparam int MIN_DIM    = 3;

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
	localparam int COLW_BITS = COL_BITS + 1;
	localparam int ROWW_BITS = ROW_BITS + 1;

	localparam int DIM_BITS       = 11;
	localparam int THRESH_BITS    = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam int IN_TDATA_BITS  = 32;
	localparam int COORD_BITS     = 10;
	localparam int STRENGTH_BITS  = 31;
	localparam int OUT_FIELD_BITS = 2 * COORD_BITS + STRENGTH_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	localparam cfg_index_t REG_IMAGE_WIDTH        = 2'd0;
	localparam cfg_index_t REG_IMAGE_HEIGHT       = 2'd1;
	localparam cfg_index_t REG_STRENGTH_THRESHOLD = 2'd2;

	localparam logic [DIM_BITS-1:0]           WIDTH_RESET  = 11'd640;
	localparam logic [DIM_BITS-1:0]           HEIGHT_RESET = 11'd480;
	localparam logic signed [THRESH_BITS-1:0] THRESH_RESET = 32'sd1;

	typedef logic signed [PIXEL_BITS-1:0] pixel_t;
	typedef logic [COL_BITS-1:0]          col_t;
	typedef logic [ROW_BITS-1:0]          row_t;
	typedef logic [COLW_BITS-1:0]         col_wide_t;
	typedef logic [ROWW_BITS-1:0]         row_wide_t;

	// Pixel held between the input register and the window stage.
	typedef struct packed {
		logic   valid;
		logic   fwd;
		col_t   col;
		row_t   row;
		pixel_t value;
	} stage_t;

endpackage

FILE: sv/tlmd_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents. No dependencies.
module tlmd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/tlmd_front.sv
// Input stage: configuration registers, column and row counters, thresholding
// and the stage 1 register. Uses tlmd_pkg.
module tlmd_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  tlmd_pkg::cfg_index_t                  cfg_index,
	input  logic [tlmd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [tlmd_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	input  logic                                  s_tuser,
	input  logic                                  take,
	output logic                                  rd_en,
	output tlmd_pkg::col_t                        rd_col,
	output tlmd_pkg::stage_t                      stage
);

	logic [tlmd_pkg::DIM_BITS-1:0]           width_q;
	logic [tlmd_pkg::DIM_BITS-1:0]           height_q;
	logic signed [tlmd_pkg::THRESH_BITS-1:0] thresh_q;
	tlmd_pkg::col_t                          col_q;
	tlmd_pkg::row_t                          row_q;

	logic                                    valid_s1;
	logic                                    fwd_s1;
	tlmd_pkg::col_t                          col_s1;
	tlmd_pkg::row_t                          row_s1;
	tlmd_pkg::pixel_t                        value_s1;

	tlmd_pkg::col_wide_t                     width_eff;
	tlmd_pkg::row_wide_t                     height_eff;
	tlmd_pkg::col_t                          col_cur;
	tlmd_pkg::row_t                          row_cur;
	tlmd_pkg::col_t                          col_next;
	tlmd_pkg::row_t                          row_next;
	tlmd_pkg::pixel_t                        pix_in;
	tlmd_pkg::pixel_t                        pix_thr;
	logic                                    accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !valid_s1 || take;
	assign rd_en    = accept;
	assign rd_col   = col_cur;

	always_comb begin
		if (int'(width_q) < tlmd_pkg::MIN_DIM) begin
			width_eff = tlmd_pkg::COLW_BITS'(tlmd_pkg::MIN_DIM);
		end else if (int'(width_q) > tlmd_pkg::MAX_WIDTH) begin
			width_eff = tlmd_pkg::COLW_BITS'(tlmd_pkg::MAX_WIDTH);
		end else begin
			width_eff = tlmd_pkg::COLW_BITS'(width_q);
		end
		if (int'(height_q) < tlmd_pkg::MIN_DIM) begin
			height_eff = tlmd_pkg::ROWW_BITS'(tlmd_pkg::MIN_DIM);
		end else if (int'(height_q) > tlmd_pkg::MAX_HEIGHT) begin
			height_eff = tlmd_pkg::ROWW_BITS'(tlmd_pkg::MAX_HEIGHT);
		end else begin
			height_eff = tlmd_pkg::ROWW_BITS'(height_q);
		end
	end

	// The start-of-frame flag restarts counting; stale counts after a size
	// change fall back to zero.
	always_comb begin
		col_cur = s_tuser ? '0 : col_q;
		row_cur = s_tuser ? '0 : row_q;
		if (tlmd_pkg::COLW_BITS'(col_cur) >= width_eff) begin
			col_cur = '0;
		end
		if (tlmd_pkg::ROWW_BITS'(row_cur) >= height_eff) begin
			row_cur = '0;
		end
		if (tlmd_pkg::COLW_BITS'(col_cur) + tlmd_pkg::COLW_BITS'(1) >= width_eff) begin
			col_next = '0;
			if (tlmd_pkg::ROWW_BITS'(row_cur) + tlmd_pkg::ROWW_BITS'(1) >= height_eff) begin
				row_next = '0;
			end else begin
				row_next = row_cur + tlmd_pkg::ROW_BITS'(1);
			end
		end else begin
			col_next = col_cur + tlmd_pkg::COL_BITS'(1);
			row_next = row_cur;
		end
	end

	assign pix_in  = s_tdata[tlmd_pkg::PIXEL_BITS-1:0];
	assign pix_thr = (pix_in < thresh_q) ? '0 : pix_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tlmd_pkg::WIDTH_RESET;
			height_q <= tlmd_pkg::HEIGHT_RESET;
			thresh_q <= tlmd_pkg::THRESH_RESET;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					tlmd_pkg::REG_IMAGE_WIDTH: begin
						width_q <= cfg_data[tlmd_pkg::DIM_BITS-1:0];
					end
					tlmd_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= cfg_data[tlmd_pkg::DIM_BITS-1:0];
					end
					tlmd_pkg::REG_STRENGTH_THRESHOLD: begin
						thresh_q <= cfg_data[tlmd_pkg::THRESH_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				col_q    <= col_next;
				row_q    <= row_next;
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// When the pixel ahead writes the same column in the same cycle as this
	// read, the RAM returns old data and the window stage forwards instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1   <= take && (col_cur == col_s1);
			col_s1   <= col_cur;
			row_s1   <= row_cur;
			value_s1 <= pix_thr;
		end
	end

	assign stage = '{valid: valid_s1, fwd: fwd_s1, col: col_s1, row: row_s1,
		value: value_s1};

endmodule

FILE: sv/tlmd_nms.sv
// Window stage: 3x3 neighborhood registers, local maximum test and the result
// register. Uses tlmd_pkg.
module tlmd_nms (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlmd_pkg::stage_t                    stage,
	input  tlmd_pkg::pixel_t                    up_rd,
	input  tlmd_pkg::pixel_t                    mid_rd,
	output logic                                take,
	output tlmd_pkg::pixel_t                    up_wr,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tlmd_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

	// Entries 0..2: column c-1 of rows r-2, r-1, r; entries 3..5: column c-2.
	tlmd_pkg::pixel_t                  win_q [6];
	tlmd_pkg::pixel_t                  fwd_up_q;
	tlmd_pkg::pixel_t                  fwd_mid_q;
	logic                              out_valid_q;
	logic [tlmd_pkg::COORD_BITS-1:0]   x_q;
	logic [tlmd_pkg::COORD_BITS-1:0]   y_q;
	logic [tlmd_pkg::STRENGTH_BITS-1:0] strength_q;

	tlmd_pkg::pixel_t                  up_eff;
	tlmd_pkg::pixel_t                  mid_eff;
	tlmd_pkg::pixel_t                  ctr;
	logic                              interior;
	logic                              hit;

	assign take    = stage.valid && (!out_valid_q || m_tready);
	assign up_eff  = stage.fwd ? fwd_up_q : up_rd;
	assign mid_eff = stage.fwd ? fwd_mid_q : mid_rd;
	assign up_wr   = mid_eff;
	assign ctr     = win_q[1];

	assign interior = (int'(stage.col) >= 2) && (int'(stage.row) >= 2);

	assign hit = interior && (ctr > tlmd_pkg::pixel_t'(0))
		&& (ctr >= win_q[3]) && (ctr >= win_q[4]) && (ctr >= win_q[5])
		&& (ctr >= win_q[0]) && (ctr >= win_q[2])
		&& (ctr >= up_eff) && (ctr >= mid_eff) && (ctr >= stage.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (take) begin
				out_valid_q <= hit;
				win_q[3]    <= win_q[0];
				win_q[4]    <= win_q[1];
				win_q[5]    <= win_q[2];
				win_q[0]    <= up_eff;
				win_q[1]    <= mid_eff;
				win_q[2]    <= stage.value;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fwd_up_q  <= mid_eff;
			fwd_mid_q <= stage.value;
			if (hit) begin
				x_q        <= tlmd_pkg::COORD_BITS'(stage.col - tlmd_pkg::COL_BITS'(1));
				y_q        <= tlmd_pkg::COORD_BITS'(stage.row - tlmd_pkg::ROW_BITS'(1));
				strength_q <= tlmd_pkg::STRENGTH_BITS'($unsigned(ctr));
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tlmd_pkg::OUT_TDATA_BITS'({strength_q, y_q, x_q});

endmodule

FILE: sv/threshold_3x3_local_max_detect.sv
// Thresholded 3x3 local maximum detector over a raster-order pixel stream.
// A result passes the stage 1 register, then the output register, once the pixel
// completing its neighborhood is accepted. Throughput: one pixel per cycle when
// not stalled, set by the single read port of each line store RAM.
// Reset: configuration returns to 640 x 480 with threshold 1, counters and the
// window clear at once; line store contents stay undefined until written.
module threshold_3x3_local_max_detect (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wen,
	input  tlmd_pkg::cfg_index_t                   cfg_index,
	input  logic [tlmd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [31:0] pixel_value
	input  logic [tlmd_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
	// [0] first_of_frame
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [9:0] corner_x, [19:10] corner_y, [50:20] corner_strength, [55:51] zero
	output logic [tlmd_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata
);

	tlmd_pkg::stage_t stage;
	tlmd_pkg::col_t   rd_col;
	tlmd_pkg::pixel_t up_rd;
	tlmd_pkg::pixel_t mid_rd;
	tlmd_pkg::pixel_t up_wr;
	logic             rd_en;
	logic             take;

	tlmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.take     (take),
		.rd_en    (rd_en),
		.rd_col   (rd_col),
		.stage    (stage)
	);

	// Row r-2 of the current column.
	tlmd_ram #(
		.WIDTH(tlmd_pkg::PIXEL_BITS),
		.DEPTH(tlmd_pkg::MAX_WIDTH)
	) u_line_upper (
		.clk  (clk),
		.we   (take),
		.waddr(stage.col),
		.wdata(up_wr),
		.re   (rd_en),
		.raddr(rd_col),
		.rdata(up_rd)
	);

	// Row r-1 of the current column.
	tlmd_ram #(
		.WIDTH(tlmd_pkg::PIXEL_BITS),
		.DEPTH(tlmd_pkg::MAX_WIDTH)
	) u_line_middle (
		.clk  (clk),
		.we   (take),
		.waddr(stage.col),
		.wdata(stage.value),
		.re   (rd_en),
		.raddr(rd_col),
		.rdata(mid_rd)
	);

	tlmd_nms u_nms (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.up_rd   (up_rd),
		.mid_rd  (mid_rd),
		.take    (take),
		.up_wr   (up_wr),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata (m_axis_tdata)
	);

endmodule
